// ===== rtl/lsbse_pkg.sv =====
// Shared types and constants for the LSB pixel stego embed/extract block.
package lsbse_pkg;

	// Configuration register indexes
	localparam logic CFG_MODE   = 1'b0;
	localparam logic CFG_LENGTH = 1'b1;

	// Mode codes
	localparam logic MODE_EMBED   = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	// Header is eight pixels, one length byte each
	localparam logic [3:0] HDR_PIXELS = 4'd8;

	// Pixel masks for the 3-2-3 layout
	localparam logic [7:0] KEEP_RB   = 8'hF8;
	localparam logic [7:0] KEEP_G    = 8'hFC;
	localparam logic [7:0] BYTE_RED  = 8'hE0;
	localparam logic [7:0] BYTE_GRN  = 8'h18;
	localparam logic [7:0] LOW_RB    = 8'h07;
	localparam logic [7:0] LOW_G     = 8'h03;

	typedef struct packed {
		logic [3:0]  hdr_pos;
		logic [63:0] bytes_done;
		logic [63:0] asm_len;
		logic        done;
	} state_t;

	typedef struct packed {
		logic       start_of_image;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] payload_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        byte_consumed;
		logic [7:0]  recovered_byte;
		logic        recovered_valid;
		logic [63:0] length_seen;
		logic        finished;
	} out_item_t;

endpackage

// ===== rtl/lsbse_codec.sv =====
// Per-pixel embed/extract logic: next state and result for one pixel.
module lsbse_codec (
	input  logic                 mode,
	input  logic [63:0]          payload_length,
	input  lsbse_pkg::state_t    state_cur,
	input  lsbse_pkg::in_item_t  item,
	output lsbse_pkg::state_t    state_nxt,
	output lsbse_pkg::out_item_t result
);

	lsbse_pkg::state_t st;
	logic [63:0] bytes_inc;
	logic [63:0] limit;
	logic        in_header;
	logic [2:0]  byte_sel;
	logic [7:0]  hdr_byte;
	logic [7:0]  code;
	logic [7:0]  packed_byte;
	logic        embed;
	logic [3:0]  hdr_next;
	logic [63:0] asm_next;

	// Start of image clears the state before the pixel is handled
	assign st = item.start_of_image ? '0 : state_cur;

	assign in_header   = (st.hdr_pos < lsbse_pkg::HDR_PIXELS);
	assign hdr_next    = st.hdr_pos + 4'd1;
	assign byte_sel    = 3'd7 - st.hdr_pos[2:0];
	assign hdr_byte    = payload_length[{byte_sel, 3'b000} +: 8];
	assign packed_byte = {item.red[2:0], item.green[1:0], item.blue[2:0]};
	assign asm_next    = {st.asm_len[55:0], packed_byte};

	// Saturating byte count
	assign bytes_inc = (&st.bytes_done) ? st.bytes_done : st.bytes_done + 64'd1;
	assign limit     = (mode == lsbse_pkg::MODE_EMBED) ? payload_length : st.asm_len;

	always_comb begin
		state_nxt             = st;
		result.byte_consumed  = 1'b0;
		result.recovered_byte = 8'd0;
		result.recovered_valid = 1'b0;
		result.length_seen    = 64'd0;
		embed                 = 1'b0;
		code                  = 8'd0;

		if (mode == lsbse_pkg::MODE_EMBED) begin
			if (in_header) begin
				code              = hdr_byte;
				embed             = 1'b1;
				state_nxt.hdr_pos = hdr_next;
				if (hdr_next == lsbse_pkg::HDR_PIXELS && payload_length == 64'd0) begin
					state_nxt.done = 1'b1;
				end
			end else if (!st.done) begin
				code                 = item.payload_byte;
				embed                = 1'b1;
				result.byte_consumed = 1'b1;
				state_nxt.bytes_done = bytes_inc;
				if (bytes_inc >= limit) begin
					state_nxt.done = 1'b1;
				end
			end
		end else begin
			if (in_header) begin
				state_nxt.asm_len = asm_next;
				state_nxt.hdr_pos = hdr_next;
				if (hdr_next == lsbse_pkg::HDR_PIXELS && asm_next == 64'd0) begin
					state_nxt.done = 1'b1;
				end
			end else if (!st.done) begin
				result.recovered_byte  = packed_byte;
				result.recovered_valid = 1'b1;
				state_nxt.bytes_done   = bytes_inc;
				if (bytes_inc >= limit) begin
					state_nxt.done = 1'b1;
				end
			end
			result.length_seen = state_nxt.asm_len;
		end

		// Low-bit substitution, or pass-through
		if (embed) begin
			result.red   = (item.red & lsbse_pkg::KEEP_RB)
				| ((code & lsbse_pkg::BYTE_RED) >> 5);
			result.green = (item.green & lsbse_pkg::KEEP_G)
				| ((code & lsbse_pkg::BYTE_GRN) >> 3);
			result.blue  = (item.blue & lsbse_pkg::KEEP_RB) | (code & lsbse_pkg::LOW_RB);
		end else begin
			result.red   = item.red;
			result.green = item.green;
			result.blue  = item.blue;
		end
		result.finished = state_nxt.done;
	end

endmodule

// ===== rtl/lsb_pixel_stego_embed_extract_top.sv =====
// Top level of the LSB pixel stego embed/extract block: pipeline and config.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in      | input     | in_valid/in_stall  | start_of_image, rgb_in, payload_byte
//  out     | output    | out_valid/out_stall| rgb_out, consumed, recovered, status
//  cfg     | input     | cfg_we             | cfg_index, cfg_data (64 bits)
//
// One pixel per clock unless out_stall holds the pipe: input register, the
// per-pixel logic, result register. The 64-bit saturating byte-count add
// and compare sets the critical path.
// Reset clears the pipeline valids, the header/byte state and the configuration registers.
// An output stall backs up through both stages to in_stall in the same cycle.
module lsb_pixel_stego_embed_extract_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        start_of_image,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic [7:0]  payload_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic        byte_consumed,
	output logic [7:0]  recovered_byte,
	output logic        recovered_valid,
	output logic [63:0] length_seen,
	output logic        finished,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	logic                 mode_q;
	logic [63:0]          length_q;
	lsbse_pkg::state_t    state_q;
	lsbse_pkg::state_t    state_nxt;
	lsbse_pkg::in_item_t  item_s1;
	logic                 valid_s1;
	lsbse_pkg::out_item_t result;
	lsbse_pkg::out_item_t res_s2;
	logic                 valid_s2;
	logic                 load_s2;
	logic                 load_s1;

	// Pipeline advance
	assign load_s2  = valid_s1 && (!valid_s2 || !out_stall);
	assign load_s1  = in_valid && !in_stall;
	assign in_stall = valid_s1 && !load_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= lsbse_pkg::MODE_EMBED;
			length_q <= 64'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				lsbse_pkg::CFG_MODE:   mode_q   <= cfg_data[0];
				lsbse_pkg::CFG_LENGTH: length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= '{start_of_image, red_in, green_in, blue_in, payload_byte};
		end
	end

	lsbse_codec u_codec (
		.mode           (mode_q),
		.payload_length (length_q),
		.state_cur      (state_q),
		.item           (item_s1),
		.state_nxt      (state_nxt),
		.result         (result)
	);

	// Header and byte-count state advances as a pixel moves to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (load_s2) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			res_s2 <= result;
		end
	end

	assign out_valid       = valid_s2;
	assign red_out         = res_s2.red;
	assign green_out       = res_s2.green;
	assign blue_out        = res_s2.blue;
	assign byte_consumed   = res_s2.byte_consumed;
	assign recovered_byte  = res_s2.recovered_byte;
	assign recovered_valid = res_s2.recovered_valid;
	assign length_seen     = res_s2.length_seen;
	assign finished        = res_s2.finished;

endmodule

// ===== dv/tb_lsb_pixel_stego_embed_extract_top.sv =====
// Self-checking testbench for the LSB pixel stego embed/extract top level.
`timescale 1ns / 1ps

module tb_lsb_pixel_stego_embed_extract_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 4;

	// Clock, reset and block inputs, all known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        start_of_image = 1'b0;
	logic [7:0]  red_in = '0;
	logic [7:0]  green_in = '0;
	logic [7:0]  blue_in = '0;
	logic [7:0]  payload_byte = '0;
	logic        out_stall = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = lsbse_pkg::CFG_MODE;
	logic [63:0] cfg_data = '0;

	logic        in_stall;
	logic        out_valid;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic        byte_consumed;
	logic [7:0]  recovered_byte;
	logic        recovered_valid;
	logic [63:0] length_seen;
	logic        finished;

	// Predictor copy of the registers and the per-image state
	logic        cur_mode = lsbse_pkg::MODE_EMBED;
	logic [63:0] cur_len = '0;
	logic [3:0]  hdr_pos = '0;
	logic [63:0] byte_cnt = '0;
	logic [63:0] asm_len = '0;
	logic        done_f = 1'b0;

	lsbse_pkg::out_item_t pending_px[$];
	int        mismatches = 0;
	int        px_sent = 0;
	int        cyc = 0;
	bit        gaps_on = 1'b1;
	int        hold_req = 0;

	lsb_pixel_stego_embed_extract_top DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.start_of_image  (start_of_image),
		.red_in          (red_in),
		.green_in        (green_in),
		.blue_in         (blue_in),
		.payload_byte    (payload_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.red_out         (red_out),
		.green_out       (green_out),
		.blue_out        (blue_out),
		.byte_consumed   (byte_consumed),
		.recovered_byte  (recovered_byte),
		.recovered_valid (recovered_valid),
		.length_seen     (length_seen),
		.finished        (finished),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Count one handled payload byte, saturating, and flag completion
	function automatic void bump_count(input logic [63:0] limit);
		if (byte_cnt != '1)
			byte_cnt++;
		if (byte_cnt >= limit)
			done_f = 1'b1;
	endfunction

	// Expected result for one accepted pixel; advances the predictor state
	function automatic lsbse_pkg::out_item_t stego_pixel(input lsbse_pkg::in_item_t px);
		lsbse_pkg::out_item_t o;
		logic [7:0] c;
		bit         embed;
		int         sh;
		o = '0;
		embed = 1'b0;
		c = '0;
		o.red = px.red;
		o.green = px.green;
		o.blue = px.blue;
		if (px.start_of_image) begin
			hdr_pos = '0;
			byte_cnt = '0;
			asm_len = '0;
			done_f = 1'b0;
		end
		if (cur_mode == lsbse_pkg::MODE_EMBED) begin
			if (hdr_pos < lsbse_pkg::HDR_PIXELS) begin
				// length header, most significant byte first
				sh = 8 * (7 - int'(hdr_pos));
				c = cur_len[sh +: 8];
				embed = 1'b1;
				hdr_pos++;
				if (hdr_pos == lsbse_pkg::HDR_PIXELS && cur_len == 0)
					done_f = 1'b1;
			end else if (!done_f) begin
				c = px.payload_byte;
				embed = 1'b1;
				o.byte_consumed = 1'b1;
				bump_count(cur_len);
			end
			if (embed) begin
				o.red = {px.red[7:3], c[7:5]};
				o.green = {px.green[7:2], c[4:3]};
				o.blue = {px.blue[7:3], c[2:0]};
			end
		end else begin
			c = {px.red[2:0], px.green[1:0], px.blue[2:0]};
			if (hdr_pos < lsbse_pkg::HDR_PIXELS) begin
				asm_len = {asm_len[55:0], c};
				hdr_pos++;
				if (hdr_pos == lsbse_pkg::HDR_PIXELS && asm_len == 0)
					done_f = 1'b1;
			end else if (!done_f) begin
				o.recovered_byte = c;
				o.recovered_valid = 1'b1;
				bump_count(asm_len);
			end
			o.length_seen = asm_len;
		end
		o.finished = done_f;
		return o;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Result check, prediction of accepted pixels, register tracking
	always @(posedge clk) begin : scoreboard
		lsbse_pkg::out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_px.size() == 0) begin
					$error("result transfer with no pixel outstanding");
					mismatches++;
				end else begin
					want = pending_px.pop_front();
					check_field("red_out", want.red, red_out);
					check_field("green_out", want.green, green_out);
					check_field("blue_out", want.blue, blue_out);
					check_field("byte_consumed", want.byte_consumed, byte_consumed);
					check_field("recovered_byte", want.recovered_byte, recovered_byte);
					check_field("recovered_valid", want.recovered_valid, recovered_valid);
					check_field("length_seen", want.length_seen, length_seen);
					check_field("finished", want.finished, finished);
				end
			end
			if (in_valid && !in_stall)
				pending_px.push_back(stego_pixel('{start_of_image, red_in, green_in,
					blue_in, payload_byte}));
			if (cfg_we) begin
				if (cfg_index == lsbse_pkg::CFG_MODE)
					cur_mode = cfg_data[0];
				else
					cur_len = cfg_data;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Output side stall: random bursts, or a long hold-off on request
	initial begin : sink_stall
		int n;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				n = hold_req;
				hold_req = 0;
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic lsbse_pkg::in_item_t rand_pixel();
		lsbse_pkg::in_item_t px;
		px.start_of_image = 1'b0;
		px.red = 8'($urandom);
		px.green = 8'($urandom);
		px.blue = 8'($urandom);
		px.payload_byte = 8'($urandom);
		return px;
	endfunction

	// Random pixel whose low bits carry the given byte in 3-2-3 layout
	function automatic lsbse_pkg::in_item_t carry_pixel(input logic [7:0] b);
		lsbse_pkg::in_item_t px;
		px = rand_pixel();
		px.red = {px.red[7:3], b[7:5]};
		px.green = {px.green[7:2], b[4:3]};
		px.blue = {px.blue[7:3], b[2:0]};
		return px;
	endfunction

	// One pixel transfer; starts and ends at a rising edge
	task automatic send_px(input lsbse_pkg::in_item_t px);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_of_image <= px.start_of_image;
		red_in <= px.red;
		green_in <= px.green;
		blue_in <= px.blue;
		payload_byte <= px.payload_byte;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		px_sent++;
	endtask

	// Wait until every outstanding pixel has come back and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_px.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mode write with random upper data bits, which the block must ignore
	task automatic set_mode(input logic m);
		logic [63:0] val;
		val = {$urandom, $urandom};
		val[0] = m;
		write_reg(lsbse_pkg::CFG_MODE, val);
	endtask

	// Reset state, no start mark: zero length header then pass-through
	task automatic test_no_start_mark();
		lsbse_pkg::in_item_t px;
		for (int i = 0; i < 9; i++) begin
			if (i[0])
				px = '{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00};
			else
				px = '{1'b0, 8'h00, 8'h00, 8'h00, 8'hFF};
			send_px(px);
		end
		drain();
	endtask

	// Extract a one-byte payload, pixel extremes, then a pixel after finish
	task automatic test_extract_short();
		lsbse_pkg::in_item_t px;
		logic [7:0] hi;
		logic [7:0] b;
		set_mode(lsbse_pkg::MODE_EXTRACT);
		write_reg(lsbse_pkg::CFG_LENGTH, '1);
		for (int i = 0; i < 8; i++) begin
			hi = i[0] ? 8'h00 : 8'hFF;
			b = (i == 7) ? 8'h01 : 8'h00;
			px.start_of_image = (i == 0);
			px.red = (hi & lsbse_pkg::KEEP_RB) | {5'b0, b[7:5]};
			px.green = (hi & lsbse_pkg::KEEP_G) | {6'b0, b[4:3]};
			px.blue = (hi & lsbse_pkg::KEEP_RB) | {5'b0, b[2:0]};
			px.payload_byte = hi;
			send_px(px);
		end
		send_px('{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00});
		send_px('{1'b0, 8'h00, 8'h00, 8'h00, 8'hFF});
		drain();
	endtask

	// Mode flips partway through one image; counters carry across
	task automatic test_mode_switch();
		lsbse_pkg::in_item_t px;
		set_mode(lsbse_pkg::MODE_EMBED);
		write_reg(lsbse_pkg::CFG_LENGTH, '1);
		for (int i = 0; i < 4; i++) begin
			px = rand_pixel();
			px.start_of_image = (i == 0);
			px.payload_byte = 8'hFF;
			send_px(px);
		end
		drain();
		set_mode(lsbse_pkg::MODE_EXTRACT);
		repeat (3) send_px(rand_pixel());
		drain();
		set_mode(lsbse_pkg::MODE_EMBED);
		write_reg(lsbse_pkg::CFG_LENGTH, 64'd1);
		repeat (3) send_px(rand_pixel());
		drain();
	endtask

	// One image: fresh settings, header, body and a few trailing pixels
	task automatic random_image(input bit idle_ok);
		logic [63:0] len;
		logic        xmode;
		bit          sof_first;
		int          kind;
		int          n_px;
		lsbse_pkg::in_item_t px;
		kind = $urandom_range(0, 9);
		if (kind == 0)
			len = '0;
		else if (kind == 1)
			len = {$urandom, $urandom};
		else
			len = 64'($urandom_range(1, 24));
		xmode = 1'($urandom_range(0, 1));
		drain();
		set_mode(xmode);
		write_reg(lsbse_pkg::CFG_LENGTH, xmode ? {$urandom, $urandom} : len);
		gaps_on = idle_ok && ($urandom_range(0, 3) != 0);
		sof_first = $urandom_range(0, 7) != 0;
		n_px = 8 + ((len > 24) ? 24 : int'(len)) + $urandom_range(0, 4);
		for (int i = 0; i < n_px; i++) begin
			// extract images mostly carry a proper header; kind 2 is noise
			if (xmode && kind != 2 && i < 8)
				px = carry_pixel(len[8 * (7 - i) +: 8]);
			else
				px = rand_pixel();
			if (i == 0)
				px.start_of_image = sof_first;
			else
				px.start_of_image = ($urandom_range(0, 59) == 0);
			send_px(px);
		end
	endtask

	// Long output hold-off while the sender keeps offering pixels
	task automatic test_backpressure();
		lsbse_pkg::in_item_t px;
		drain();
		gaps_on = 1'b0;
		set_mode(lsbse_pkg::MODE_EMBED);
		write_reg(lsbse_pkg::CFG_LENGTH, 64'd8);
		hold_req = 80;
		for (int i = 0; i < 20; i++) begin
			px = rand_pixel();
			px.start_of_image = (i == 0);
			send_px(px);
		end
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_start_mark();
		test_extract_short();
		test_mode_switch();
		while (px_sent < 380)
			random_image(1'b1);
		test_backpressure();
		while (px_sent < 460)
			random_image(1'b0);
		drain();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/lsbse_pkg.sv
rtl/lsbse_codec.sv
rtl/lsb_pixel_stego_embed_extract_top.sv
dv/tb_lsb_pixel_stego_embed_extract_top.sv
